/* rtl/lcbm_pkg.sv */
package lcbm_pkg;

	// Access codes carried by the opcode field
	localparam logic [2:0] OP_CPU_READ   = 3'd0;
	localparam logic [2:0] OP_CPU_WRITE  = 3'd1;
	localparam logic [2:0] OP_VIDEO_SET  = 3'd2;
	localparam logic [2:0] OP_VIDEO_READ = 3'd3;
	localparam logic [2:0] OP_VIDEO_WRITE = 3'd4;

	// Target region codes
	localparam logic [3:0] REGION_NONE      = 4'd0;
	localparam logic [3:0] REGION_SYSRAM    = 4'd1;
	localparam logic [3:0] REGION_PPU       = 4'd2;
	localparam logic [3:0] REGION_APU       = 4'd3;
	localparam logic [3:0] REGION_BACKUP    = 4'd4;
	localparam logic [3:0] REGION_PRG       = 4'd5;
	localparam logic [3:0] REGION_MAPPER    = 4'd6;
	localparam logic [3:0] REGION_CHRROM    = 4'd7;
	localparam logic [3:0] REGION_CHRRAM    = 4'd8;
	localparam logic [3:0] REGION_NAMETABLE = 4'd9;
	localparam logic [3:0] REGION_LAST      = REGION_NAMETABLE;

	// Configuration register indexes
	localparam logic [1:0] CFG_PRG_MASK     = 2'd0;
	localparam logic [1:0] CFG_CHR_MASK     = 2'd1;
	localparam logic [1:0] CFG_BRAM_PRESENT = 2'd2;
	localparam logic [1:0] CFG_BRAM_MASK    = 2'd3;

	localparam int CFG_DATA_W = 13;
	localparam int ADDR_W     = 22;

	typedef struct packed {
		logic [7:0]  prg_mask;
		logic [7:0]  chr_mask;
		logic        bram_present;
		logic [12:0] bram_mask;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       prg_bank;
		logic [3:0][7:0]  chr_bank;
		logic             latch_low;
		logic             latch_high;
		logic [13:0]      video_addr;
		logic             mirror;
	} map_state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] bus_address;
		logic [7:0]  write_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]        target_region;
		logic [ADDR_W-1:0] mem_address;
		logic              mirror_horizontal;
	} result_t;

endpackage

/* rtl/lcbm_state.sv */
module lcbm_state (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [lcbm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               upd,
	input  lcbm_pkg::map_state_t               st_nxt,
	output lcbm_pkg::cfg_t                     cfg,
	output lcbm_pkg::map_state_t               st
);

	lcbm_pkg::cfg_t       cfg_q;
	lcbm_pkg::map_state_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_mask     <= 8'd7;
			cfg_q.chr_mask     <= 8'd31;
			cfg_q.bram_present <= 1'b1;
			cfg_q.bram_mask    <= 13'h1FFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcbm_pkg::CFG_PRG_MASK:     cfg_q.prg_mask     <= cfg_data[7:0];
				lcbm_pkg::CFG_CHR_MASK:     cfg_q.chr_mask     <= cfg_data[7:0];
				lcbm_pkg::CFG_BRAM_PRESENT: cfg_q.bram_present <= cfg_data[0];
				lcbm_pkg::CFG_BRAM_MASK:    cfg_q.bram_mask    <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.prg_bank   <= '0;
			st_q.chr_bank   <= '0;
			st_q.latch_low  <= 1'b1;
			st_q.latch_high <= 1'b1;
			st_q.video_addr <= '0;
			st_q.mirror     <= 1'b0;
		end else if (upd) begin
			st_q <= st_nxt;
		end
	end

	assign cfg = cfg_q;
	assign st  = st_q;

endmodule

/* rtl/lcbm_decode.sv */
module lcbm_decode (
	input  lcbm_pkg::item_t      item,
	input  lcbm_pkg::cfg_t       cfg,
	input  lcbm_pkg::map_state_t st,
	output lcbm_pkg::result_t    res,
	output lcbm_pkg::map_state_t st_nxt
);

	logic [15:0] a;
	logic [7:0]  d;
	logic [13:0] va;
	logic [10:0] nt_addr;
	logic [7:0]  chr_sel;

	assign a  = item.bus_address;
	assign d  = item.write_byte;
	assign va = st.video_addr;

	// Nametable fold: horizontal keeps A11 as the page bit
	assign nt_addr = st.mirror ? {va[11], va[9:0]} : va[10:0];
	assign chr_sel = va[12] ? (st.latch_high ? st.chr_bank[3] : st.chr_bank[2])
	                        : (st.latch_low  ? st.chr_bank[1] : st.chr_bank[0]);

	always_comb begin
		logic [13:0] va_new;
		st_nxt            = st;
		res.target_region = lcbm_pkg::REGION_NONE;
		res.mem_address   = '0;
		va_new            = a[13:0];
		unique case (item.opcode)
			lcbm_pkg::OP_CPU_READ, lcbm_pkg::OP_CPU_WRITE: begin
				if (!a[15]) begin
					unique case (a[14:13])
						2'd0: begin
							res.target_region = lcbm_pkg::REGION_SYSRAM;
							res.mem_address   = {11'd0, a[10:0]};
						end
						2'd1: begin
							res.target_region = lcbm_pkg::REGION_PPU;
							res.mem_address   = {6'd0, a};
						end
						2'd2: begin
							res.target_region = lcbm_pkg::REGION_APU;
							res.mem_address   = {6'd0, a};
						end
						default: begin
							if (cfg.bram_present) begin
								res.target_region = lcbm_pkg::REGION_BACKUP;
								res.mem_address   = {9'd0, a[12:0] & cfg.bram_mask};
							end
						end
					endcase
				end else if (item.opcode == lcbm_pkg::OP_CPU_READ) begin
					res.target_region = lcbm_pkg::REGION_PRG;
					res.mem_address   = {(a[14] ? cfg.prg_mask : st.prg_bank), a[13:0]};
				end else if (a[15:13] != 3'b100) begin
					res.target_region = lcbm_pkg::REGION_MAPPER;
					res.mem_address   = {6'd0, a};
					unique case (a[14:12])
						3'd2:    st_nxt.prg_bank    = d & cfg.prg_mask;
						3'd3:    st_nxt.chr_bank[0] = d & cfg.chr_mask;
						3'd4:    st_nxt.chr_bank[1] = d & cfg.chr_mask;
						3'd5:    st_nxt.chr_bank[2] = d & cfg.chr_mask;
						3'd6:    st_nxt.chr_bank[3] = d & cfg.chr_mask;
						default: st_nxt.mirror      = d[0];
					endcase
				end
			end
			lcbm_pkg::OP_VIDEO_SET: begin
				st_nxt.video_addr = va_new;
				unique case (va_new[12:4])
					9'h0FD:  st_nxt.latch_low  = 1'b0;
					9'h0FE:  st_nxt.latch_low  = 1'b1;
					9'h1FD:  st_nxt.latch_high = 1'b0;
					9'h1FE:  st_nxt.latch_high = 1'b1;
					default: ;
				endcase
			end
			lcbm_pkg::OP_VIDEO_READ: begin
				if (!va[13]) begin
					res.target_region = lcbm_pkg::REGION_CHRROM;
					res.mem_address   = {2'd0, chr_sel, va[11:0]};
				end else begin
					res.target_region = lcbm_pkg::REGION_NAMETABLE;
					res.mem_address   = {11'd0, nt_addr};
				end
			end
			lcbm_pkg::OP_VIDEO_WRITE: begin
				if (!va[13]) begin
					res.target_region = lcbm_pkg::REGION_CHRRAM;
					res.mem_address   = {9'd0, va[12:0]};
				end else begin
					res.target_region = lcbm_pkg::REGION_NAMETABLE;
					res.mem_address   = {11'd0, nt_addr};
				end
			end
			default: ;
		endcase
		// Report mirroring as it stands after this item
		res.mirror_horizontal = st_nxt.mirror;
	end

endmodule

/* rtl/latched_chr_bank_mapper_core.sv */
// Throughput: one item per cycle while the result channel is not stalled; the input
// register feeds one shallow decode stage into the result register, and bank, latch
// and mirroring updates apply from the next item.
// Reset (arst_n low, asynchronous): both stages empty, banks zero, both pattern
// latches set, video address zero, vertical mirroring, configuration at its defaults.
module latched_chr_bank_mapper_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [2:0]                       opcode,
	input  logic [15:0]                      bus_address,
	input  logic [7:0]                       write_byte,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [3:0]                       target_region,
	output logic [lcbm_pkg::ADDR_W-1:0]      mem_address,
	output logic                             mirror_horizontal,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [lcbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                 valid_s1;
	lcbm_pkg::item_t      item_s1;
	logic                 valid_s2;
	lcbm_pkg::result_t    res_s2;

	lcbm_pkg::cfg_t       cfg;
	lcbm_pkg::map_state_t st;
	lcbm_pkg::map_state_t st_nxt;
	lcbm_pkg::result_t    res;

	logic adv_s2;   // result register can take a new item this cycle
	logic fire_s1;  // item in the input register moves on and commits its state update

	assign adv_s2   = !valid_s2 || !out_stall;
	assign fire_s1  = valid_s1 && adv_s2;
	// Stall the source only when the input register holds an item that cannot move
	assign in_stall = valid_s1 && !adv_s2;

	// Input register: load whenever it is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.opcode      <= opcode;
			item_s1.bus_address <= bus_address;
			item_s1.write_byte  <= write_byte;
		end
	end

	// Mapper state and configuration; state advances only with a committed item
	lcbm_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.upd       (fire_s1),
		.st_nxt    (st_nxt),
		.cfg       (cfg),
		.st        (st)
	);

	// Address decode and register update for the item in the input register
	lcbm_decode u_decode (
		.item   (item_s1),
		.cfg    (cfg),
		.st     (st),
		.res    (res),
		.st_nxt (st_nxt)
	);

	// Result register: hold while stalled, advance otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid         = valid_s2;
	assign target_region     = res_s2.target_region;
	assign mem_address       = res_s2.mem_address;
	assign mirror_horizontal = res_s2.mirror_horizontal;

endmodule

/* rtl/lcbm_checker.sv */
module lcbm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [3:0]                       target_region,
	input logic [lcbm_pkg::ADDR_W-1:0]      mem_address,
	input logic                             mirror_horizontal
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(target_region) && $stable(mem_address)
			&& $stable(mirror_horizontal))
		else $error("stalled result changed");

	a_region_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> target_region <= lcbm_pkg::REGION_LAST)
		else $error("region code out of range");

	// Items that hit no region carry a zero address
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target_region == lcbm_pkg::REGION_NONE |-> mem_address == '0)
		else $error("nonzero address with no region");

	// Nametable and system RAM addresses fit in 2K
	a_small_windows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target_region == lcbm_pkg::REGION_NAMETABLE
			|| target_region == lcbm_pkg::REGION_SYSRAM) |-> mem_address[21:11] == '0)
		else $error("window address too wide");

endmodule

bind latched_chr_bank_mapper_core lcbm_checker u_lcbm_checker (.*);

/* verif/latched_chr_bank_mapper_core_tb.sv */
`timescale 1ns / 100ps

module latched_chr_bank_mapper_core_tb;

	// Opcodes 5 to 7 carry no access; the block must answer with region none
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// Mapper register select by the top nibble of a CPU write at $A000 and above
	localparam logic [3:0] SEL_PRG    = 4'hA;
	localparam logic [3:0] SEL_CHR0   = 4'hB;
	localparam logic [3:0] SEL_CHR1   = 4'hC;
	localparam logic [3:0] SEL_CHR2   = 4'hD;
	localparam logic [3:0] SEL_CHR3   = 4'hE;

	// Video address tags (after masking with $1FF0) that move the pattern latches
	localparam logic [13:0] TAG_MASK       = 14'h1FF0;
	localparam logic [13:0] TAG_LOW_CLEAR  = 14'h0FD0;
	localparam logic [13:0] TAG_LOW_SET    = 14'h0FE0;
	localparam logic [13:0] TAG_HIGH_CLEAR = 14'h1FD0;
	localparam logic [13:0] TAG_HIGH_SET   = 14'h1FE0;

	localparam int REPORT_LIMIT   = 10;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int LONG_HOLD      = 400;
	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 240;

	// Expected-result store plus a cycle-free model of the mapper state
	class mapper_scoreboard;
		lcbm_pkg::result_t pending[$];
		int          mismatches;
		// configuration
		logic [7:0]  prg_mask;
		logic [7:0]  chr_mask;
		logic        bram_present;
		logic [12:0] bram_mask;
		// mapper state
		logic [7:0]  prg_bank;
		logic [7:0]  chr_bank[4];
		logic        latch_low;
		logic        latch_high;
		logic [13:0] vaddr;
		logic        mirror;

		function new();
			mismatches   = 0;
			prg_mask     = 8'd7;
			chr_mask     = 8'd31;
			bram_present = 1'b1;
			bram_mask    = 13'h1FFF;
			prg_bank     = '0;
			foreach (chr_bank[i]) chr_bank[i] = '0;
			latch_low    = 1'b1;
			latch_high   = 1'b1;
			vaddr        = '0;
			mirror       = 1'b0;
		endfunction

		function void set_config(logic [1:0] idx, logic [12:0] val);
			case (idx)
				lcbm_pkg::CFG_PRG_MASK:     prg_mask = val[7:0];
				lcbm_pkg::CFG_CHR_MASK:     chr_mask = val[7:0];
				lcbm_pkg::CFG_BRAM_PRESENT: bram_present = val[0];
				lcbm_pkg::CFG_BRAM_MASK:    bram_mask = val;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		function int failures();
			return mismatches + pending.size();
		endfunction

		// CPU space below $8000, shared by reads and writes
		function lcbm_pkg::result_t cpu_window(logic [15:0] a);
			lcbm_pkg::result_t r;
			r = '0;
			case (a[15:13])
				3'd0: begin
					r.target_region = lcbm_pkg::REGION_SYSRAM;
					r.mem_address = {11'b0, a[10:0]};
				end
				3'd1: begin
					r.target_region = lcbm_pkg::REGION_PPU;
					r.mem_address = {6'b0, a};
				end
				3'd2: begin
					r.target_region = lcbm_pkg::REGION_APU;
					r.mem_address = {6'b0, a};
				end
				default: begin
					if (bram_present) begin
						r.target_region = lcbm_pkg::REGION_BACKUP;
						r.mem_address = {9'b0, a[12:0] & bram_mask};
					end
				end
			endcase
			return r;
		endfunction

		function logic [lcbm_pkg::ADDR_W-1:0] nametable_addr();
			if (mirror)
				return {11'b0, vaddr[11], vaddr[9:0]};
			return {11'b0, vaddr[10:0]};
		endfunction

		// Apply one accepted item to the model and queue what it should produce
		function void note_item(logic [2:0] op, logic [15:0] a, logic [7:0] d);
			lcbm_pkg::result_t r;
			logic [7:0] bank;
			r = '0;
			case (op)
				lcbm_pkg::OP_CPU_READ: begin
					if (!a[15])
						r = cpu_window(a);
					else begin
						bank = (a < 16'hC000) ? prg_bank : prg_mask;
						r.target_region = lcbm_pkg::REGION_PRG;
						r.mem_address = {bank, a[13:0]};
					end
				end
				lcbm_pkg::OP_CPU_WRITE: begin
					if (!a[15])
						r = cpu_window(a);
					else if (a >= 16'hA000) begin
						r.target_region = lcbm_pkg::REGION_MAPPER;
						r.mem_address = {6'b0, a};
						case (a[15:12])
							SEL_PRG:  prg_bank = d & prg_mask;
							SEL_CHR0: chr_bank[0] = d & chr_mask;
							SEL_CHR1: chr_bank[1] = d & chr_mask;
							SEL_CHR2: chr_bank[2] = d & chr_mask;
							SEL_CHR3: chr_bank[3] = d & chr_mask;
							default:  mirror = d[0];
						endcase
					end
				end
				lcbm_pkg::OP_VIDEO_SET: begin
					vaddr = a[13:0];
					case (vaddr & TAG_MASK)
						TAG_LOW_CLEAR:  latch_low = 1'b0;
						TAG_LOW_SET:    latch_low = 1'b1;
						TAG_HIGH_CLEAR: latch_high = 1'b0;
						TAG_HIGH_SET:   latch_high = 1'b1;
						default: ;
					endcase
				end
				lcbm_pkg::OP_VIDEO_READ: begin
					case (vaddr[13:12])
						2'd0: begin
							bank = latch_low ? chr_bank[1] : chr_bank[0];
							r.target_region = lcbm_pkg::REGION_CHRROM;
							r.mem_address = {2'b0, bank, vaddr[11:0]};
						end
						2'd1: begin
							bank = latch_high ? chr_bank[3] : chr_bank[2];
							r.target_region = lcbm_pkg::REGION_CHRROM;
							r.mem_address = {2'b0, bank, vaddr[11:0]};
						end
						default: begin
							r.target_region = lcbm_pkg::REGION_NAMETABLE;
							r.mem_address = nametable_addr();
						end
					endcase
				end
				lcbm_pkg::OP_VIDEO_WRITE: begin
					if (!vaddr[13]) begin
						r.target_region = lcbm_pkg::REGION_CHRRAM;
						r.mem_address = {9'b0, vaddr[12:0]};
					end else begin
						r.target_region = lcbm_pkg::REGION_NAMETABLE;
						r.mem_address = nametable_addr();
					end
				end
				default: ;
			endcase
			r.mirror_horizontal = mirror;
			pending.push_back(r);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%s", what);
		endfunction

		function void check_result(logic [3:0] region, logic [lcbm_pkg::ADDR_W-1:0] addr,
				logic mirror_h);
			lcbm_pkg::result_t want;
			if (pending.size() == 0) begin
				flag($sformatf("unexpected result: region %0d addr %h mirror %b",
					region, addr, mirror_h));
				return;
			end
			want = pending.pop_front();
			if (region !== want.target_region || addr !== want.mem_address ||
					mirror_h !== want.mirror_horizontal)
				flag($sformatf({"mismatch: expected region %0d addr %h mirror %b, ",
					"got region %0d addr %h mirror %b"},
					want.target_region, want.mem_address, want.mirror_horizontal,
					region, addr, mirror_h));
		endfunction
	endclass

	// Clock, reset and block ports; every input known from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [2:0]            opcode = lcbm_pkg::OP_CPU_READ;
	logic [15:0]           bus_address = '0;
	logic [7:0]            write_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [3:0]            target_region;
	logic [lcbm_pkg::ADDR_W-1:0]     mem_address;
	logic                  mirror_horizontal;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_index = lcbm_pkg::CFG_PRG_MASK;
	logic [lcbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	mapper_scoreboard sb;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	int quiet_cycles = 0;

	latched_chr_bank_mapper_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.bus_address(bus_address),
		.write_byte(write_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.target_region(target_region),
		.mem_address(mem_address),
		.mirror_horizontal(mirror_horizontal),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random stalls, or a long hold-off once requested so the block backs up
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			hold_request <= 1'b0;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor both channels at the edge; the watchdog counts edges with no transfer
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_item(opcode, bus_address, write_byte);
		if (out_valid && !out_stall)
			sb.check_result(target_region, mem_address, mirror_horizontal);
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Offer one item, with random gaps ahead of it, and hold it until taken
	task automatic send_item(input logic [2:0] op, input logic [15:0] addr,
			input logic [7:0] data);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		bus_address <= addr;
		write_byte <= data;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Mostly meaningful traffic: mapper writes, latch tags followed by pattern fetches
	task automatic send_random_item();
		int          pick;
		logic [2:0]  op;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [13:0] tag;
		pick = $urandom_range(99);
		addr = 16'($urandom);
		data = 8'($urandom);
		if (pick < 28)
			op = lcbm_pkg::OP_CPU_READ;
		else if (pick < 48) begin
			op = lcbm_pkg::OP_CPU_WRITE;
			// steer most writes into the mapper registers
			if ($urandom_range(99) < 60)
				addr = 16'($urandom_range(16'hA000, 16'hFFFF));
		end else if (pick < 73) begin
			op = lcbm_pkg::OP_VIDEO_SET;
			if ($urandom_range(99) < 45) begin
				case ($urandom_range(3))
					0: tag = TAG_LOW_CLEAR;
					1: tag = TAG_LOW_SET;
					2: tag = TAG_HIGH_CLEAR;
					default: tag = TAG_HIGH_SET;
				endcase
				addr = {3'($urandom_range(7)), tag[12:4], 4'($urandom_range(15))};
			end
		end else if (pick < 93)
			op = lcbm_pkg::OP_VIDEO_READ;
		else if (pick < 98)
			op = lcbm_pkg::OP_VIDEO_WRITE;
		else
			op = 3'($urandom_range(5, 7));
		send_item(op, addr, data);
	endtask

	// Drop valid and wait until every expected result is back, then let the block settle
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [1:0] idx, input logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_config(idx, val);
	endtask

	// Write all four registers back to back; only called while the block is idle
	task automatic write_config(input logic [7:0] prg_mask, input logic [7:0] chr_mask,
			input logic present, input logic [12:0] bmask);
		cfg_beat(lcbm_pkg::CFG_PRG_MASK, {5'b0, prg_mask});
		cfg_beat(lcbm_pkg::CFG_CHR_MASK, {5'b0, chr_mask});
		cfg_beat(lcbm_pkg::CFG_BRAM_PRESENT, {12'b0, present});
		cfg_beat(lcbm_pkg::CFG_BRAM_MASK, bmask);
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 12;
		recv_stall_pct = 83;

		// Directed pass at reset configuration: every window and register, two latch tags
		send_item(lcbm_pkg::OP_CPU_READ, 16'h0000, 8'h00);
		send_item(lcbm_pkg::OP_CPU_READ, 16'h3FFF, 8'hFF);
		send_item(lcbm_pkg::OP_CPU_READ, 16'h5FFF, 8'h00);
		send_item(lcbm_pkg::OP_CPU_READ, 16'h6000, 8'h00);
		send_item(lcbm_pkg::OP_CPU_READ, 16'h8000, 8'h00);
		send_item(lcbm_pkg::OP_CPU_READ, 16'hC000, 8'h00);
		send_item(lcbm_pkg::OP_CPU_READ, 16'hFFFF, 8'h00);
		// write into the switchable low PRG window is ignored
		send_item(lcbm_pkg::OP_CPU_WRITE, 16'h8000, 8'hFF);
		send_item(lcbm_pkg::OP_CPU_WRITE, 16'hA000, 8'hFF);
		send_item(lcbm_pkg::OP_CPU_WRITE, 16'hB000, 8'hFF);
		send_item(lcbm_pkg::OP_CPU_WRITE, 16'hCFFF, 8'h55);
		send_item(lcbm_pkg::OP_CPU_WRITE, 16'hD000, 8'hAA);
		send_item(lcbm_pkg::OP_CPU_WRITE, 16'hE000, 8'h0F);
		send_item(lcbm_pkg::OP_CPU_WRITE, 16'hF000, 8'h01);
		send_item(lcbm_pkg::OP_CPU_READ, 16'hBFFF, 8'h00);
		send_item(lcbm_pkg::OP_VIDEO_SET, 16'h0FD0, 8'h00);
		send_item(lcbm_pkg::OP_VIDEO_READ, 16'h0000, 8'h00);
		send_item(lcbm_pkg::OP_VIDEO_SET, 16'h1FEF, 8'h00);
		send_item(lcbm_pkg::OP_VIDEO_READ, 16'hFFFF, 8'hFF);
		// top of video space, nametable with horizontal mirroring
		send_item(lcbm_pkg::OP_VIDEO_SET, 16'hFFFF, 8'hFF);
		send_item(lcbm_pkg::OP_VIDEO_READ, 16'h0000, 8'h00);
		send_item(lcbm_pkg::OP_VIDEO_WRITE, 16'h0000, 8'h00);
		send_item(lcbm_pkg::OP_VIDEO_SET, 16'h0123, 8'h00);
		send_item(lcbm_pkg::OP_VIDEO_WRITE, 16'hFFFF, 8'hFF);
		send_item(OP_UNUSED, 16'hFFFF, 8'hFF);
		send_item(lcbm_pkg::OP_CPU_WRITE, 16'hFFFF, 8'h00);
		settle();

		// Random phases, each under a fresh configuration; the first two at the extremes
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase * 3 / PHASES)
				0: begin
					send_gap_pct = 12;
					recv_stall_pct = 83;
				end
				1: begin
					send_gap_pct = 83;
					recv_stall_pct = 12;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			if (phase == 0)
				write_config(8'd3, 8'd1, 1'b0, 13'h0000);
			else if (phase == 1)
				write_config(8'd255, 8'd255, 1'b1, 13'h1FFF);
			else
				write_config(8'((1 << $urandom_range(2, 8)) - 1),
					8'((1 << $urandom_range(1, 8)) - 1),
					1'($urandom_range(1)), 13'($urandom_range(8191)));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// with no sender gaps, hold the receiver off long enough to fill the block
				if (phase == PHASES - 2 && n == 40)
					hold_request = 1'b1;
				send_random_item();
			end
			settle();
		end

		if (sb.failures() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
rtl/lcbm_pkg.sv
rtl/lcbm_state.sv
rtl/lcbm_decode.sv
rtl/latched_chr_bank_mapper_core.sv
rtl/lcbm_checker.sv
verif/latched_chr_bank_mapper_core_tb.sv
